// File: hdl/fpcd_pkg.sv
package fpcd_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 64;

  // Registers sit at byte addresses 0 and 8; bit 3 of the address picks one.
  localparam logic REG_FRAME_BYTES = 1'b0;
  localparam logic REG_DICTIONARY  = 1'b1;

  localparam logic [11:0] FRAME_BYTES_RST = 12'd8;

  typedef struct packed {
    logic [11:0] frame_bytes;
    logic [63:0] dictionary;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
  } res_t;

endpackage

// File: hdl/frame_prefix_code_decompressor.sv
// Decodes a compressed configuration stream one bit per clock cycle unless a stalled output holds
// it. An input word is taken in IDLE, then the decoder reads its eight code bits one by one in RUN
// and, when the word yields a decoded byte, hands over its final byte in FLUSH; no new word is
// taken until the decoder is back in IDLE. A frame end cuts the word short and the remaining
// padding bits are skipped. A stalled output holds the decoder. It is a single bit-serial decode
// stage with a one-word holding register in front of the output register.
module frame_prefix_code_decompressor (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         out_frame_end,
  output logic                         out_run_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fpcd_pkg::ADDR_W-1:0]  paddr,
  input  logic [fpcd_pkg::DATA_W-1:0]  pwdata,
  output logic [fpcd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  fpcd_pkg::cfg_t cfg;
  fpcd_pkg::res_t push_res;
  fpcd_pkg::res_t out_r;
  logic           out_valid_r;
  logic           out_free;
  logic           push;

  fpcd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpcd_dec u_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .cfg      (cfg),
    .out_free (out_free),
    .push     (push),
    .push_res (push_res)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= push_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_r.out_byte;
  assign out_frame_end = out_r.frame_end;
  assign out_run_last  = out_r.run_last;

endmodule

// File: hdl/fpcd_cfg.sv
module fpcd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fpcd_pkg::ADDR_W-1:0]  paddr,
  input  logic [fpcd_pkg::DATA_W-1:0]  pwdata,
  output logic [fpcd_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output fpcd_pkg::cfg_t               cfg
);

  logic [11:0] frame_bytes_r;
  logic [63:0] dictionary_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bytes_r <= fpcd_pkg::FRAME_BYTES_RST;
      dictionary_r  <= '0;
    end else if (wr_en) begin
      unique case (paddr[3])
        fpcd_pkg::REG_FRAME_BYTES: frame_bytes_r <= pwdata[11:0];
        fpcd_pkg::REG_DICTIONARY:  dictionary_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      fpcd_pkg::REG_FRAME_BYTES: prdata = {52'd0, frame_bytes_r};
      fpcd_pkg::REG_DICTIONARY:  prdata = dictionary_r;
      default:                   prdata = '0;
    endcase
  end

  assign cfg.frame_bytes = frame_bytes_r;
  assign cfg.dictionary  = dictionary_r;

endmodule

// File: hdl/fpcd_dec.sv
module fpcd_dec (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  output logic            in_stall,
  input  fpcd_pkg::cfg_t  cfg,
  input  logic            out_free,
  output logic            push,
  output fpcd_pkg::res_t  push_res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [2:0]  bitcnt_r, bitcnt_nxt;
  logic [9:0]  pend_bits_r, pend_bits_nxt;
  logic [3:0]  pend_cnt_r, pend_cnt_nxt;
  logic [11:0] bytes_done_r, bytes_done_nxt;
  logic        held_v_r, held_v_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_end_r, held_end_nxt;

  logic [9:0]  nbits;
  logic [3:0]  ncnt;
  logic [2:0]  sel;
  logic        done;
  logic [7:0]  val;
  logic [11:0] bd_inc;
  logic        frame_end;
  logic        last_bit;
  logic        blocked;

  assign nbits     = {pend_bits_r[8:0], sh_r[7]};
  assign ncnt      = pend_cnt_r + 4'd1;
  assign sel       = nbits[2:0];
  assign bd_inc    = bytes_done_r + 12'd1;
  assign frame_end = bd_inc >= cfg.frame_bytes;
  assign last_bit  = bitcnt_r == 3'd7;

  always_comb begin
    done = 1'b0;
    val  = 8'd0;
    priority if (ncnt == 4'd1 && nbits == 10'd0) begin
      done = 1'b1;
    end else if (ncnt == 4'd6 && nbits[9:3] == 7'd4) begin
      done = 1'b1;
      val  = 8'd1 << sel;
    end else if (ncnt == 4'd6 && nbits[9:3] == 7'd5) begin
      done = 1'b1;
      val  = cfg.dictionary[{sel, 3'd0} +: 8];
    end else if (ncnt >= 4'd10) begin
      done = 1'b1;
      val  = nbits[7:0];
    end else begin
      done = 1'b0;
    end
  end

  assign blocked  = done && held_v_r && !out_free;
  assign in_stall = state_r != ST_IDLE;

  always_comb begin
    state_nxt      = state_r;
    sh_nxt         = sh_r;
    bitcnt_nxt     = bitcnt_r;
    pend_bits_nxt  = pend_bits_r;
    pend_cnt_nxt   = pend_cnt_r;
    bytes_done_nxt = bytes_done_r;
    held_v_nxt     = held_v_r;
    held_byte_nxt  = held_byte_r;
    held_end_nxt   = held_end_r;
    push           = 1'b0;
    push_res       = {held_byte_r, held_end_r, 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sh_nxt     = in_byte;
          bitcnt_nxt = 3'd0;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!blocked) begin
          sh_nxt     = {sh_r[6:0], 1'b0};
          bitcnt_nxt = bitcnt_r + 3'd1;
          if (done) begin
            push           = held_v_r;
            pend_bits_nxt  = '0;
            pend_cnt_nxt   = '0;
            held_v_nxt     = 1'b1;
            held_byte_nxt  = val;
            held_end_nxt   = frame_end;
            bytes_done_nxt = frame_end ? 12'd0 : bd_inc;
          end else begin
            pend_bits_nxt = nbits;
            pend_cnt_nxt  = ncnt;
          end
          if ((done && frame_end) || last_bit) begin
            state_nxt = (done || held_v_r) ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        push_res = {held_byte_r, held_end_r, 1'b1};
        if (out_free) begin
          push       = 1'b1;
          held_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_bits_r  <= '0;
      pend_cnt_r   <= '0;
      bytes_done_r <= '0;
      held_v_r     <= 1'b0;
      bitcnt_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      pend_bits_r  <= pend_bits_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      bytes_done_r <= bytes_done_nxt;
      held_v_r     <= held_v_nxt;
      bitcnt_r     <= bitcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r        <= sh_nxt;
    held_byte_r <= held_byte_nxt;
    held_end_r  <= held_end_nxt;
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_cnt_r <= 4'd9)
    else $error("pending code longer than nine bits");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("word pushed into a full output register");

  a_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && done && frame_end && !blocked) |=> state_r == ST_FLUSH)
    else $error("frame end did not stop the bit reader");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !held_v_r)
    else $error("decoded word left behind at end of input word");

endmodule
